@@ design/odhpm_pkg.sv @@
// ----------------------------------------------------------------------------
// odhpm_pkg
// Shared types, register codes, sine table and lane arithmetic for the
// heading-stabilized omni drive mixer.
// ----------------------------------------------------------------------------
package odhpm_pkg;

    // Fraction bits of the rescaled sine magnitude (8..20)
    localparam int SINE_FRACTION_BITS = 15;
    localparam int SIN_UP     = (SINE_FRACTION_BITS >= 15) ? SINE_FRACTION_BITS - 15 : 0;
    localparam int SIN_DN     = (SINE_FRACTION_BITS < 15) ? 15 - SINE_FRACTION_BITS : 0;
    localparam int SIN_HALF   = (SIN_DN == 0) ? 0 : (1 << (SIN_DN - 1));
    localparam int SIN_W      = SINE_FRACTION_BITS + 1;
    localparam int SIN_CALC_W = 17 + SIN_UP;
    localparam int PROD_W     = SIN_W + 7;

    // Configuration port
    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = 16;
    localparam logic [CFG_INDEX_W-1:0] REG_WHEEL_LIMIT      = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_CORRECTION_LIMIT = 8'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_P_GAIN_Q16       = 8'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_D_GAIN           = 8'd3;

    localparam logic [6:0]  RST_WHEEL_LIMIT      = 7'd40;
    localparam logic [6:0]  RST_CORRECTION_LIMIT = 7'd25;
    localparam logic [15:0] RST_P_GAIN_Q16       = 16'd5898;
    localparam logic [3:0]  RST_D_GAIN           = 4'd1;

    // Gyro wrap
    localparam logic [9:0]         GYRO_WRAP_LIMIT = 10'd400;
    localparam logic signed [10:0] GYRO_WRAP_SPAN  = 11'sd800;

    // Angles
    localparam logic [9:0] DEG_FULL_W   = 10'd360;
    localparam logic [8:0] DEG_FULL     = 9'd360;
    localparam logic [8:0] DEG_QUARTER  = 9'd90;
    localparam logic [8:0] DEG_HALF     = 9'd180;
    localparam logic [8:0] DEG_3QUARTER = 9'd270;

    localparam int NUM_WHEELS = 4;
    // Lane order A, B, C, D: sine argument offsets
    localparam logic [8:0] WHEEL_OFFSET [NUM_WHEELS] = '{9'd300, 9'd60, 9'd225, 9'd135};
    // A and C: negated base, correction added. B and D: plain base, correction subtracted.
    localparam logic [NUM_WHEELS-1:0] WHEEL_FLIP = 4'b0101;

    localparam logic [15:0] SINE_Q15 [0:90] = '{
        16'd0,     16'd572,   16'd1144,  16'd1715,  16'd2286,  16'd2856,  16'd3425,
        16'd3993,  16'd4560,  16'd5126,  16'd5690,  16'd6252,  16'd6813,  16'd7371,
        16'd7927,  16'd8481,  16'd9032,  16'd9580,  16'd10126, 16'd10668, 16'd11207,
        16'd11743, 16'd12275, 16'd12803, 16'd13328, 16'd13848, 16'd14365, 16'd14876,
        16'd15384, 16'd15886, 16'd16384, 16'd16877, 16'd17364, 16'd17847, 16'd18324,
        16'd18795, 16'd19261, 16'd19720, 16'd20174, 16'd20622, 16'd21063, 16'd21498,
        16'd21926, 16'd22348, 16'd22763, 16'd23170, 16'd23571, 16'd23965, 16'd24351,
        16'd24730, 16'd25102, 16'd25466, 16'd25822, 16'd26170, 16'd26510, 16'd26842,
        16'd27166, 16'd27482, 16'd27789, 16'd28088, 16'd28378, 16'd28660, 16'd28932,
        16'd29197, 16'd29452, 16'd29698, 16'd29935, 16'd30163, 16'd30382, 16'd30592,
        16'd30792, 16'd30983, 16'd31164, 16'd31336, 16'd31499, 16'd31651, 16'd31795,
        16'd31928, 16'd32052, 16'd32166, 16'd32270, 16'd32365, 16'd32449, 16'd32524,
        16'd32588, 16'd32643, 16'd32688, 16'd32723, 16'd32748, 16'd32763, 16'd32768
    };

    typedef struct packed {
        logic [9:0] gyro_reading;
        logic [8:0] direction_deg;
        logic [6:0] drive_power;
    } in_item_t;

    typedef struct packed {
        logic [7:0]        pwm_a;
        logic [7:0]        pwm_b;
        logic [7:0]        pwm_c;
        logic [7:0]        pwm_d;
        logic signed [7:0] heading_correction;
    } out_item_t;

    typedef struct packed {
        logic [6:0]  wheel_limit;
        logic [6:0]  correction_limit;
        logic [15:0] p_gain_q16;
        logic [3:0]  d_gain;
    } cfg_t;

    // Reduce an angle below 720 into 0..359
    function automatic logic [8:0] wrap_deg(logic [9:0] a);
        if (a >= DEG_FULL_W) begin
            return 9'(a - DEG_FULL_W);
        end
        return a[8:0];
    endfunction

    // First-quadrant sine magnitude rescaled to SINE_FRACTION_BITS
    function automatic logic [SIN_W-1:0] sine_mag(logic [6:0] idx);
        logic [SIN_CALC_W-1:0] v;
        v = SIN_CALC_W'(SINE_Q15[idx]);
        if (SINE_FRACTION_BITS >= 15) begin
            return SIN_W'(v << SIN_UP);
        end
        return SIN_W'((v + SIN_CALC_W'(SIN_HALF)) >> SIN_DN);
    endfunction

    // Signed sin(angle) * power, truncated toward zero, optionally negated
    function automatic logic signed [7:0] wheel_base(logic [8:0] angle, logic [6:0] power,
                                                     logic flip);
        logic [6:0]        idx;
        logic              s_neg;
        logic [PROD_W-1:0] mag;
        logic [6:0]        r;
        if (angle <= DEG_QUARTER) begin
            idx   = angle[6:0];
            s_neg = 1'b0;
        end else if (angle <= DEG_HALF) begin
            idx   = 7'(DEG_HALF - angle);
            s_neg = 1'b0;
        end else if (angle <= DEG_3QUARTER) begin
            idx   = 7'(angle - DEG_HALF);
            s_neg = 1'b1;
        end else begin
            idx   = 7'(DEG_FULL - angle);
            s_neg = 1'b1;
        end
        mag = PROD_W'(sine_mag(idx)) * PROD_W'(power);
        r   = 7'(mag >> SINE_FRACTION_BITS);
        if (s_neg ^ flip) begin
            return -$signed({1'b0, r});
        end
        return $signed({1'b0, r});
    endfunction

    // Symmetric clamp, then sign-magnitude with bit 7 as sign
    function automatic logic [7:0] sat_sign_mag(logic signed [8:0] v, logic [6:0] lim);
        logic signed [8:0] l;
        logic signed [8:0] c;
        logic [6:0]        m;
        l = $signed({2'b00, lim});
        if (v > l) begin
            c = l;
        end else if (v < -l) begin
            c = -l;
        end else begin
            c = v;
        end
        m = c[8] ? 7'(-c) : c[6:0];
        return {c[8], m};
    endfunction

endpackage

@@ design/odhpm_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// odhpm_cfg_regs
// Configuration register file: motor and correction limits, PD gains.
// ----------------------------------------------------------------------------
module odhpm_cfg_regs (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [odhpm_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [odhpm_pkg::CFG_DATA_W-1:0]    cfg_data,
    output odhpm_pkg::cfg_t                     cfg
);

    odhpm_pkg::cfg_t cfg_reg, cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (cfg_index)
                odhpm_pkg::REG_WHEEL_LIMIT:      cfg_next.wheel_limit      = cfg_data[6:0];
                odhpm_pkg::REG_CORRECTION_LIMIT: cfg_next.correction_limit = cfg_data[6:0];
                odhpm_pkg::REG_P_GAIN_Q16:       cfg_next.p_gain_q16       = cfg_data[15:0];
                odhpm_pkg::REG_D_GAIN:           cfg_next.d_gain           = cfg_data[3:0];
                default:                         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.wheel_limit      <= odhpm_pkg::RST_WHEEL_LIMIT;
            cfg_reg.correction_limit <= odhpm_pkg::RST_CORRECTION_LIMIT;
            cfg_reg.p_gain_q16       <= odhpm_pkg::RST_P_GAIN_Q16;
            cfg_reg.d_gain           <= odhpm_pkg::RST_D_GAIN;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

@@ design/odhpm_heading_pd.sv @@
// ----------------------------------------------------------------------------
// odhpm_heading_pd
// Heading error from the gyro sample, PD correction, symmetric clamp.
// Holds the previous negated gyro sample for the derivative term.
// ----------------------------------------------------------------------------
module odhpm_heading_pd (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic [9:0]        gyro_reading,
    input  logic              update,
    input  odhpm_pkg::cfg_t   cfg,
    output logic signed [7:0] correction
);

    logic signed [10:0] prev_error_reg, prev_error_next;
    logic signed [10:0] g_s;
    logic signed [10:0] err_half;
    logic signed [11:0] err2;
    logic               err_neg;
    logic [9:0]         emag;
    logic [25:0]        pprod;
    logic [9:0]         pmag;
    logic signed [10:0] pterm;
    logic signed [10:0] cur_err;
    logic signed [11:0] diff;
    logic signed [16:0] dterm;
    logic signed [17:0] pd_sum;
    logic signed [17:0] lim;

    always_comb begin
        g_s      = $signed({1'b0, gyro_reading});
        // wrap readings above the threshold into the negative half
        err_half = (gyro_reading > odhpm_pkg::GYRO_WRAP_LIMIT) ?
                   g_s - odhpm_pkg::GYRO_WRAP_SPAN : g_s;
        err2     = $signed({err_half, 1'b0});
        err_neg  = err2[11];
        emag     = err_neg ? 10'(-err2) : 10'(err2);
        pprod    = 26'(emag) * 26'(cfg.p_gain_q16);
        pmag     = pprod[25:16];
        pterm    = err_neg ? -$signed({1'b0, pmag}) : $signed({1'b0, pmag});

        cur_err  = -g_s;
        diff     = 12'(cur_err) - 12'(prev_error_reg);
        dterm    = 17'(diff) * $signed({13'b0, cfg.d_gain});

        pd_sum   = 18'(pterm) + 18'(dterm);
        lim      = $signed({11'b0, cfg.correction_limit});
        if (pd_sum > lim) begin
            correction = 8'(lim);
        end else if (pd_sum < -lim) begin
            correction = 8'(-lim);
        end else begin
            correction = 8'(pd_sum);
        end

        prev_error_next = update ? cur_err : prev_error_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_error_reg <= '0;
        end else begin
            prev_error_reg <= prev_error_next;
        end
    end

endmodule

@@ design/odhpm_wheel_mix.sv @@
// ----------------------------------------------------------------------------
// odhpm_wheel_mix
// Four wheel lanes: sine-table base command, heading correction, clamp and
// sign-magnitude encoding.
// ----------------------------------------------------------------------------
module odhpm_wheel_mix (
    input  logic [8:0]        direction_deg,
    input  logic [6:0]        drive_power,
    input  logic signed [7:0] correction,
    input  logic [6:0]        wheel_limit,
    output logic [7:0]        pwm [odhpm_pkg::NUM_WHEELS]
);

    logic [8:0]        dir_r;
    logic [8:0]        angle  [odhpm_pkg::NUM_WHEELS];
    logic signed [7:0] base   [odhpm_pkg::NUM_WHEELS];
    logic signed [8:0] mixed  [odhpm_pkg::NUM_WHEELS];

    always_comb begin
        dir_r = odhpm_pkg::wrap_deg({1'b0, direction_deg});
        for (int i = 0; i < odhpm_pkg::NUM_WHEELS; i++) begin
            angle[i] = odhpm_pkg::wrap_deg(10'(dir_r) + 10'(odhpm_pkg::WHEEL_OFFSET[i]));
            base[i]  = odhpm_pkg::wheel_base(angle[i], drive_power,
                                             odhpm_pkg::WHEEL_FLIP[i]);
            // add correction on flipped lanes, subtract on the others
            if (odhpm_pkg::WHEEL_FLIP[i]) begin
                mixed[i] = 9'(base[i]) + 9'(correction);
            end else begin
                mixed[i] = 9'(base[i]) - 9'(correction);
            end
            pwm[i] = odhpm_pkg::sat_sign_mag(mixed[i], wheel_limit);
        end
    end

endmodule

@@ design/omni_drive_heading_pd_mixer_top.sv @@
// ----------------------------------------------------------------------------
// omni_drive_heading_pd_mixer_top
// Heading-stabilized four-wheel omni drive mixer.
//
// Input channel s_*: one transfer per control tick carrying the gyro sample,
// travel direction and drive power. Result channel m_*: one transfer per
// input carrying four sign-magnitude wheel commands and the clamped heading
// correction. Configuration channel cfg_*: register index and data, always
// ready; write only while no tick is in flight.
//
// An input transfer is held in the input register for one pass of PD and
// wheel arithmetic, and the outcome is registered in the result register,
// which drives m_valid. Throughput is one tick per cycle while m_ready
// stays high; the result register frees the input stage, so a new tick
// is taken while a finished result waits. When the receiver stalls, the
// result holds, then the input stage holds, then s_ready drops.
// The derivative history advances as a tick moves into the result register.
// Reset (aresetn low, synchronous) empties both stages, zeroes the history
// and loads the register defaults.
// ----------------------------------------------------------------------------
module omni_drive_heading_pd_mixer_top (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  odhpm_pkg::in_item_t                 s_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output odhpm_pkg::out_item_t                m_data,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [odhpm_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [odhpm_pkg::CFG_DATA_W-1:0]    cfg_data
);

    odhpm_pkg::cfg_t      cfg;
    logic                 in_valid_reg, in_valid_next;
    odhpm_pkg::in_item_t  in_data_reg;
    logic                 m_valid_reg, m_valid_next;
    odhpm_pkg::out_item_t m_data_reg;
    odhpm_pkg::out_item_t result;
    logic                 advance;
    logic                 s_xfer;
    logic signed [7:0]    correction;
    logic [7:0]           pwm [odhpm_pkg::NUM_WHEELS];

    odhpm_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    odhpm_heading_pd u_pd (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .gyro_reading (in_data_reg.gyro_reading),
        .update       (advance),
        .cfg          (cfg),
        .correction   (correction)
    );

    odhpm_wheel_mix u_mix (
        .direction_deg (in_data_reg.direction_deg),
        .drive_power   (in_data_reg.drive_power),
        .correction    (correction),
        .wheel_limit   (cfg.wheel_limit),
        .pwm           (pwm)
    );

    assign advance = in_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign s_xfer  = s_valid && s_ready;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    always_comb begin
        result.pwm_a              = pwm[0];
        result.pwm_b              = pwm[1];
        result.pwm_c              = pwm[2];
        result.pwm_d              = pwm[3];
        result.heading_correction = correction;

        in_valid_next = in_valid_reg;
        if (s_xfer) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end

        m_valid_next = m_valid_reg;
        if (advance) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // payload: load on transfer, hold otherwise
    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            in_data_reg <= s_data;
        end
        if (advance) begin
            m_data_reg <= result;
        end
    end

endmodule

@@ design/odhpm_checker.sv @@
// ----------------------------------------------------------------------------
// odhpm_checker
// Port-level checks for the omni drive mixer, bound to the top level.
// ----------------------------------------------------------------------------
module odhpm_checker (
    input logic                                aclk,
    input logic                                aresetn,
    input logic                                s_valid,
    input logic                                s_ready,
    input logic                                m_valid,
    input logic                                m_ready,
    input odhpm_pkg::out_item_t                m_data
);

    // a stalled result holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // reset empties the result register
    assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // correction is clamped to a 7-bit magnitude
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.heading_correction != -8'sd128)
        else $error("correction outside clamp range");

    // zero is sent as plain zero, never as negative zero
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.pwm_a != 8'h80 && m_data.pwm_b != 8'h80 &&
                    m_data.pwm_c != 8'h80 && m_data.pwm_d != 8'h80)
        else $error("negative zero wheel command");

    // an empty result register never blocks the input side
    assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid && s_valid && $past(!m_valid) && $past(aresetn) |-> s_ready)
        else $error("input stalled with empty pipeline");

endmodule

bind omni_drive_heading_pd_mixer_top odhpm_checker u_odhpm_checker (.*);
